// ----- sv/rlrd_pkg.sv -----
`timescale 1ns / 1ps

package rlrd_pkg;

  // coordinate width covers start + extent and the y drift of a steep line
  localparam int CoordW = 14;
  // error width covers the growth of the error term on steep lines
  localparam int ErrW = 26;

  localparam logic [7:0] SPACE_CODE = 8'd32;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [ErrW-1:0]   err_t;

  typedef enum logic [2:0] {
    CMD_PLOT    = 3'd0,
    CMD_LINE    = 3'd1,
    CMD_HSPAN   = 3'd2,
    CMD_VSPAN   = 3'd3,
    CMD_OUTLINE = 3'd4,
    CMD_FILL    = 3'd5,
    CMD_READ    = 3'd6
  } cmd_e;

  typedef enum logic [1:0] {
    WALK_LINE,
    WALK_VERT,
    WALK_FILL
  } walk_mode_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic signed [11:0] x_start;
    logic signed [11:0] y_start;
    logic signed [11:0] x_end;
    logic signed [11:0] y_end;
    logic [10:0]        extent_w;
    logic [10:0]        extent_h;
    logic [7:0]         color_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_value;
    logic       clipped;
  } out_item_t;

  // walker state handed to the step unit
  typedef struct packed {
    walk_mode_e mode;
    coord_t     x;
    coord_t     y;
    coord_t     x_first;
    coord_t     x_last;
    coord_t     y_last;
    err_t       e;
    err_t       dy;
    err_t       dyc;
    err_t       dx;
  } walk_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    err_t   e;
    logic   last;
  } step_t;

endpackage

// ----- sv/rlrd_frame_mem.sv -----
`timescale 1ns / 1ps

module rlrd_frame_mem #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/rlrd_step_unit.sv -----
`timescale 1ns / 1ps

module rlrd_step_unit import rlrd_pkg::*; (
  input  walk_t walk_i,
  output step_t step_o
);

  err_t   e_sum;
  err_t   e_mag;
  err_t   e_twice;
  logic   y_step;
  coord_t x_inc;
  coord_t y_inc;
  coord_t y_toward;

  always_comb begin
    e_sum    = walk_i.e + walk_i.dy;
    e_mag    = e_sum[ErrW-1] ? -e_sum : e_sum;
    e_twice  = err_t'({e_mag[ErrW-2:0], 1'b0});
    y_step   = (walk_i.dy != '0) && (e_twice >= walk_i.dx);
    x_inc    = walk_i.x + coord_t'(1);
    y_inc    = walk_i.y + coord_t'(1);
    y_toward = walk_i.dy[ErrW-1] ? (walk_i.y - coord_t'(1)) : y_inc;

    step_o.x    = walk_i.x;
    step_o.y    = walk_i.y;
    step_o.e    = walk_i.e;
    step_o.last = 1'b1;

    case (walk_i.mode)
      WALK_LINE: begin
        step_o.x    = x_inc;
        step_o.y    = y_step ? y_toward : walk_i.y;
        // dyc holds dy - sign(dy)*dx, so e + dyc is the error after a y step
        step_o.e    = y_step ? (walk_i.e + walk_i.dyc) : e_sum;
        step_o.last = (walk_i.x == walk_i.x_last);
      end
      WALK_VERT: begin
        step_o.y    = y_inc;
        step_o.last = (walk_i.y == walk_i.y_last);
      end
      WALK_FILL: begin
        if (walk_i.x == walk_i.x_last) begin
          step_o.x    = walk_i.x_first;
          step_o.y    = y_inc;
          step_o.last = (walk_i.y == walk_i.y_last);
        end else begin
          step_o.x    = x_inc;
          step_o.last = 1'b0;
        end
      end
      default: begin
        step_o.last = 1'b1;
      end
    endcase
  end

endmodule

// ----- sv/raster_line_rect_drawer.sv -----
`timescale 1ns / 1ps

// Command engine that draws 8-bit pixel codes into an on-chip frame buffer of
// MAP_WIDTH x MAP_HEIGHT entries through one write port, one pixel per clock.
// After reset the buffer is swept to the space code, one entry per cycle, and
// no command is taken until that pass ends.
// A command is taken only while the engine is idle and then runs alone: a
// setup step, a walk step for every pixel it visits (clipped pixels of lines,
// spans and outlines are visited too), and a done step that posts the result
// once the output register is free or being taken; an outline runs four spans,
// each with its own setup. A fill visits only the visible part of its
// rectangle. A pixel read passes through the read and read-wait states, as the
// read port is registered. A finished result waits in the output register while
// the next command is taken.
module raster_line_rect_drawer import rlrd_pkg::*; #(
  parameter int MAP_WIDTH  = 64,
  parameter int MAP_HEIGHT = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int MemDepth = MAP_WIDTH * MAP_HEIGHT;
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam coord_t MapWMax = coord_t'(MAP_WIDTH - 1);
  localparam coord_t MapHMax = coord_t'(MAP_HEIGHT - 1);
  localparam logic [1:0] SegLast = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_READ,
    ST_READ_WAIT,
    ST_DONE
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] seg_q, seg_d;
  logic       clip_q, clip_d;
  logic [AddrW-1:0] clr_cnt_q, clr_cnt_d;
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q, out_d;

  in_item_t   item_q, item_d;
  walk_t      walk_q, walk_d;
  logic [7:0] rv_q, rv_d;

  step_t      step;
  logic       pix_inb;
  logic [AddrW-1:0] x_idx, y_idx, pix_addr;
  logic       mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0] mem_wdata, mem_rdata;

  coord_t xs, ys, xe, ye, rx, by;
  coord_t dx_c, dy_c;
  err_t   dx_e, dy_e, dyc_e;
  coord_t lx, hx, ly, hy;
  logic   fill_clip, fill_empty;

  rlrd_step_unit u_step (
    .walk_i (walk_q),
    .step_o (step)
  );

  rlrd_frame_mem #(
    .Depth (MemDepth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // pixel address and bounds for the walker position
  assign pix_inb  = !walk_q.x[CoordW-1] && (walk_q.x <= MapWMax) &&
                    !walk_q.y[CoordW-1] && (walk_q.y <= MapHMax);
  assign x_idx    = AddrW'($unsigned(walk_q.x));
  assign y_idx    = AddrW'($unsigned(walk_q.y));
  assign pix_addr = y_idx * AddrW'(MAP_WIDTH) + x_idx;

  assign mem_we    = (state_q == ST_CLEAR) || ((state_q == ST_WALK) && pix_inb);
  assign mem_addr  = (state_q == ST_CLEAR) ? clr_cnt_q : pix_addr;
  assign mem_wdata = (state_q == ST_CLEAR) ? SPACE_CODE : item_q.color_code;

  // command setup values
  always_comb begin
    xs    = coord_t'(item_q.x_start);
    ys    = coord_t'(item_q.y_start);
    xe    = coord_t'(item_q.x_end);
    ye    = coord_t'(item_q.y_end);
    rx    = xs + coord_t'(item_q.extent_w);
    by    = ys + coord_t'(item_q.extent_h);
    dx_c  = xe - xs;
    dy_c  = ye - ys;
    dx_e  = err_t'(dx_c);
    dy_e  = err_t'(dy_c);
    if (dy_c[CoordW-1]) begin
      dyc_e = dy_e + dx_e;
    end else if (dy_c != '0) begin
      dyc_e = dy_e - dx_e;
    end else begin
      dyc_e = '0;
    end
    lx = xs[CoordW-1] ? '0 : xs;
    ly = ys[CoordW-1] ? '0 : ys;
    hx = (rx > MapWMax) ? MapWMax : rx;
    hy = (by > MapHMax) ? MapHMax : by;
    fill_clip  = xs[CoordW-1] || ys[CoordW-1] || (rx > MapWMax) || (by > MapHMax);
    fill_empty = (xs > MapWMax) || rx[CoordW-1] || (ys > MapHMax) || by[CoordW-1];
  end

  always_comb begin
    state_d     = state_q;
    seg_d       = seg_q;
    clip_d      = clip_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    item_d      = item_q;
    walk_d      = walk_q;
    rv_d        = rv_q;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + AddrW'(1);
        if (clr_cnt_q == AddrW'(MemDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          item_d  = in_data_i;
          seg_d   = '0;
          clip_d  = 1'b0;
          rv_d    = '0;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        walk_d.mode    = WALK_LINE;
        walk_d.x       = xs;
        walk_d.y       = ys;
        walk_d.x_first = xs;
        walk_d.x_last  = xs;
        walk_d.y_last  = ys;
        walk_d.e       = '0;
        walk_d.dy      = '0;
        walk_d.dyc     = '0;
        walk_d.dx      = '0;
        state_d        = ST_WALK;
        case (cmd_e'(item_q.cmd))
          CMD_PLOT: begin
            walk_d.x_last = xs;
          end
          CMD_LINE: begin
            walk_d.x_last = xe;
            walk_d.dy     = dy_e;
            walk_d.dyc    = dyc_e;
            walk_d.dx     = dx_e;
            if (dx_c[CoordW-1]) begin
              state_d = ST_DONE;
            end
          end
          CMD_HSPAN: begin
            walk_d.x_last = xe;
            if (dx_c[CoordW-1]) begin
              state_d = ST_DONE;
            end
          end
          CMD_VSPAN: begin
            walk_d.mode   = WALK_VERT;
            walk_d.y_last = ye;
            if (dy_c[CoordW-1]) begin
              state_d = ST_DONE;
            end
          end
          CMD_OUTLINE: begin
            case (seg_q)
              2'd0: begin
                walk_d.x_last = rx;
              end
              2'd1: begin
                walk_d.mode   = WALK_VERT;
                walk_d.y_last = by;
              end
              2'd2: begin
                walk_d.y      = by;
                walk_d.x_last = rx;
              end
              default: begin
                walk_d.mode   = WALK_VERT;
                walk_d.x      = rx;
                walk_d.y_last = by;
              end
            endcase
          end
          CMD_FILL: begin
            walk_d.mode    = WALK_FILL;
            walk_d.x       = lx;
            walk_d.x_first = lx;
            walk_d.x_last  = hx;
            walk_d.y       = ly;
            walk_d.y_last  = hy;
            clip_d         = fill_clip;
            if (fill_empty) begin
              state_d = ST_DONE;
            end
          end
          CMD_READ: begin
            state_d = ST_READ;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_WALK: begin
        if (!pix_inb) begin
          clip_d = 1'b1;
        end
        walk_d.x = step.x;
        walk_d.y = step.y;
        walk_d.e = step.e;
        if (step.last) begin
          if ((cmd_e'(item_q.cmd) == CMD_OUTLINE) && (seg_q != SegLast)) begin
            seg_d   = seg_q + 2'd1;
            state_d = ST_SETUP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_READ: begin
        if (pix_inb) begin
          state_d = ST_READ_WAIT;
        end else begin
          clip_d  = 1'b1;
          state_d = ST_DONE;
        end
      end
      ST_READ_WAIT: begin
        rv_d    = mem_rdata;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d      = 1'b1;
          out_d.read_value = rv_q;
          out_d.clipped    = clip_q;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      seg_q       <= '0;
      clip_q      <= 1'b0;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      seg_q       <= seg_d;
      clip_q      <= clip_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    walk_q <= walk_d;
    rv_q   <= rv_d;
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_line_within_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) && (walk_q.mode == WALK_LINE) |-> walk_q.x <= walk_q.x_last)
    else $error("line walker passed its end x");

  a_fill_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) && (walk_q.mode == WALK_FILL) |-> pix_inb)
    else $error("fill walker left the bitmap");

  a_write_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we && (state_q == ST_WALK) |-> pix_addr <= AddrW'(MemDepth - 1))
    else $error("pixel write address beyond frame buffer");

  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_DONE))
    else $error("result posted outside the done state");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rlrd_pkg::*;

  localparam int MAP_W = 64;
  localparam int MAP_H = 64;
  localparam int FB_AW = $clog2(MAP_W * MAP_H);
  localparam logic [2:0] CMD_UNUSED = 3'd7;
  // marks a table row whose status comes from the shadow frame buffer
  localparam int BY_MODEL = -1;
  localparam int RUN_LIMIT = 3_000_000;
  localparam int LONG_HOLD = 400;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    in_item_t  item;
    logic      by_model;
    out_item_t want;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_data_o;

  logic [7:0]  shadow_fb [MAP_W*MAP_H];
  bit          clip_hit;
  out_item_t   cmd_status_q [$];
  dir_row_t    dir_tab [$];
  int          err_cnt = 0;
  int          checked_cnt = 0;
  int          clip_cnt = 0;
  int          cmd_cnt [8];
  int unsigned cyc_cnt = 0;
  bit          send_gaps;
  bit          recv_gaps;
  bit          long_hold_req;
  out_item_t   head_status;

  raster_line_rect_drawer #(
    .MAP_WIDTH (MAP_W),
    .MAP_HEIGHT(MAP_H)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) cyc_cnt <= cyc_cnt + 1;

  // shadow frame buffer

  // only called for pixels inside the bitmap
  function automatic logic [FB_AW-1:0] fb_idx(int x, int y);
    int a;
    a = y*MAP_W + x;
    return a[FB_AW-1:0];
  endfunction

  function automatic void put_px(int x, int y, logic [7:0] c);
    if (x >= 0 && x < MAP_W && y >= 0 && y < MAP_H) shadow_fb[fb_idx(x, y)] = c;
    else clip_hit = 1'b1;
  endfunction

  function automatic void hline(int x0, int x1, int y, logic [7:0] c);
    int x;
    for (x = x0; x <= x1; x++) put_px(x, y, c);
  endfunction

  function automatic void vline(int x, int y0, int y1, logic [7:0] c);
    int y;
    for (y = y0; y <= y1; y++) put_px(x, y, c);
  endfunction

  function automatic void walk_line(int x0, int y0, int x1, int y1, logic [7:0] c);
    int dx, dy, sy, e, y, mag, x;
    dx = x1 - x0;
    dy = y1 - y0;
    sy = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
    e = 0;
    y = y0;
    for (x = x0; x <= x1; x++) begin
      put_px(x, y, c);
      e += dy;
      mag = (e < 0) ? -e : e;
      // error scaled by dx, so half a pixel is dx/2
      if (2 * mag >= dx && sy != 0) begin
        y += sy;
        e -= sy * dx;
      end
    end
  endfunction

  function automatic void fill_box(int x0, int y0, int x1, int y1, logic [7:0] c);
    int lx, ly, hx, hy, x, y;
    lx = (x0 < 0) ? 0 : x0;
    ly = (y0 < 0) ? 0 : y0;
    hx = (x1 > MAP_W - 1) ? MAP_W - 1 : x1;
    hy = (y1 > MAP_H - 1) ? MAP_H - 1 : y1;
    if (x0 < 0 || y0 < 0 || x1 > MAP_W - 1 || y1 > MAP_H - 1) clip_hit = 1'b1;
    for (y = ly; y <= hy; y++)
      for (x = lx; x <= hx; x++) shadow_fb[fb_idx(x, y)] = c;
  endfunction

  function automatic out_item_t render_cmd(in_item_t it);
    int xs, ys, xe, ye, w, h;
    logic [7:0] c;
    out_item_t res;
    xs = int'($signed(it.x_start));
    ys = int'($signed(it.y_start));
    xe = int'($signed(it.x_end));
    ye = int'($signed(it.y_end));
    w = int'(it.extent_w);
    h = int'(it.extent_h);
    c = it.color_code;
    res = '0;
    clip_hit = 1'b0;
    case (it.cmd)
      CMD_PLOT:  put_px(xs, ys, c);
      CMD_LINE:  walk_line(xs, ys, xe, ye, c);
      CMD_HSPAN: hline(xs, xe, ys, c);
      CMD_VSPAN: vline(xs, ys, ye, c);
      CMD_OUTLINE: begin
        hline(xs, xs + w, ys, c);
        vline(xs, ys, ys + h, c);
        hline(xs, xs + w, ys + h, c);
        vline(xs + w, ys, ys + h, c);
      end
      CMD_FILL: fill_box(xs, ys, xs + w, ys + h, c);
      CMD_READ: begin
        if (xs >= 0 && xs < MAP_W && ys >= 0 && ys < MAP_H) begin
          res.read_value = shadow_fb[fb_idx(xs, ys)];
        end else begin
          clip_hit = 1'b1;
        end
      end
      default: ;
    endcase
    res.clipped = clip_hit;
    return res;
  endfunction

  // stimulus helpers

  function automatic dir_row_t row(logic [2:0] op, int xs, int ys, int xe, int ye,
                                   int w, int h, int color, int rv, int clip);
    dir_row_t r;
    r.item.cmd = op;
    r.item.x_start = xs[11:0];
    r.item.y_start = ys[11:0];
    r.item.x_end = xe[11:0];
    r.item.y_end = ye[11:0];
    r.item.extent_w = w[10:0];
    r.item.extent_h = h[10:0];
    r.item.color_code = color[7:0];
    r.by_model = (rv == BY_MODEL);
    r.want.read_value = rv[7:0];
    r.want.clipped = clip[0];
    return r;
  endfunction

  // mostly around the bitmap, now and then anywhere in the field
  function automatic logic [11:0] pick_coord();
    int r;
    if ($urandom_range(0, 9) == 0) r = $urandom;
    else r = int'($urandom_range(0, 79)) - 8;
    return r[11:0];
  endfunction

  function automatic logic [11:0] pick_end(logic [11:0] start);
    int r;
    if ($urandom_range(0, 9) == 0) r = $urandom;
    else r = int'($signed(start)) + int'($urandom_range(0, 44)) - 4;
    return r[11:0];
  endfunction

  function automatic logic [10:0] pick_extent();
    int r;
    if ($urandom_range(0, 11) == 0) r = $urandom;
    else r = $urandom_range(0, 20);
    return r[10:0];
  endfunction

  function automatic in_item_t random_cmd();
    in_item_t it;
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      it.cmd = CMD_READ;
    end else if (k < 28) begin
      it.cmd = CMD_UNUSED;
    end else begin
      k = $urandom_range(CMD_PLOT, CMD_FILL);
      it.cmd = k[2:0];
    end
    it.x_start = pick_coord();
    it.y_start = pick_coord();
    it.x_end = pick_end(it.x_start);
    it.y_end = pick_end(it.y_start);
    it.extent_w = pick_extent();
    it.extent_h = pick_extent();
    k = $urandom;
    it.color_code = k[7:0];
    return it;
  endfunction

  task automatic issue_cmd(input in_item_t item, input bit by_model, input out_item_t want);
    out_item_t got;
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    got = render_cmd(item);
    cmd_status_q.push_back(by_model ? got : want);
    cmd_cnt[item.cmd]++;
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cmd_status_q.size() != 0) @(posedge clk_i);
  endtask

  // receiver side stall
  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // result checker, one transaction per edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cmd_status_q.size() == 0) begin
        $error("result with no command pending: read_value=%0h clipped=%0b",
               out_data_o.read_value, out_data_o.clipped);
        err_cnt++;
      end else begin
        head_status = cmd_status_q.pop_front();
        checked_cnt++;
        if (head_status.clipped) clip_cnt++;
        if (out_data_o.read_value !== head_status.read_value) begin
          $error("read_value: expected %0h, got %0h", head_status.read_value,
                 out_data_o.read_value);
          err_cnt++;
        end
        if (out_data_o.clipped !== head_status.clipped) begin
          $error("clipped: expected %0b, got %0b", head_status.clipped, out_data_o.clipped);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    wait (cyc_cnt >= RUN_LIMIT);
    $error("timeout after %0d cycles, %0d results outstanding", RUN_LIMIT,
           cmd_status_q.size());
    $display("status: fail");
    $finish;
  end

  initial begin
    in_item_t  it;
    out_item_t nil;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    nil = '0;
    foreach (shadow_fb[i]) shadow_fb[i] = SPACE_CODE;
    foreach (cmd_cnt[i]) cmd_cnt[i] = 0;

    //                        op           xs     ys     xe    ye   w     h     color
    dir_tab.push_back(row(CMD_READ,     0,     0,     0,    0,   0,    0,    0,
                          SPACE_CODE, 0));
    dir_tab.push_back(row(CMD_READ,     -1,    0,     0,    0,   0,    0,    0,    0, 1));
    dir_tab.push_back(row(CMD_READ,     64,    63,    0,    0,   0,    0,    0,    0, 1));
    dir_tab.push_back(row(CMD_PLOT,     0,     0,     0,    0,   0,    0,    'hff, 0, 0));
    dir_tab.push_back(row(CMD_PLOT,     63,    63,    0,    0,   0,    0,    'h00, 0, 0));
    dir_tab.push_back(row(CMD_PLOT,     -2048, -2048, 0,    0,   0,    0,    'haa, 0, 1));
    dir_tab.push_back(row(CMD_PLOT,     2047,  2047,  0,    0,   0,    0,    'haa, 0, 1));
    dir_tab.push_back(row(CMD_READ,     0,     0,     0,    0,   0,    0,    0,    'hff, 0));
    dir_tab.push_back(row(CMD_READ,     63,    63,    0,    0,   0,    0,    0,    'h00, 0));
    dir_tab.push_back(row(CMD_LINE,     2,     3,     40,   20,  0,    0,    'h55,
                          BY_MODEL, 0));
    // falling slope
    dir_tab.push_back(row(CMD_LINE,     0,     63,    63,   0,   0,    0,    'h56,
                          BY_MODEL, 0));
    // steep: y creeps one step per x
    dir_tab.push_back(row(CMD_LINE,     10,    0,     12,   60,  0,    0,    'h57,
                          BY_MODEL, 0));
    dir_tab.push_back(row(CMD_LINE,     5,     5,     5,    50,  0,    0,    'h58, 0, 0));
    dir_tab.push_back(row(CMD_LINE,     40,    10,    2,    10,  0,    0,    'h59, 0, 0));
    dir_tab.push_back(row(CMD_LINE,     -2048, -2048, 2047, 2047, 0,   0,    'h11, 0, 1));
    dir_tab.push_back(row(CMD_HSPAN,    0,     7,     63,   0,   0,    0,    'h21, 0, 0));
    dir_tab.push_back(row(CMD_HSPAN,    10,    7,     9,    0,   0,    0,    'h22, 0, 0));
    dir_tab.push_back(row(CMD_VSPAN,    7,     0,     0,    63,  0,    0,    'h23, 0, 0));
    dir_tab.push_back(row(CMD_VSPAN,    7,     10,    0,    9,   0,    0,    'h24, 0, 0));
    dir_tab.push_back(row(CMD_OUTLINE,  -2048, -2048, 0,    0,   2047, 2047, 'h7e, 0, 1));
    dir_tab.push_back(row(CMD_OUTLINE,  1,     1,     0,    0,   0,    0,    'h7f, 0, 0));
    dir_tab.push_back(row(CMD_FILL,     0,     0,     0,    0,   63,   63,   'h3c, 0, 0));
    dir_tab.push_back(row(CMD_READ,     30,    30,    0,    0,   0,    0,    0,    'h3c, 0));
    dir_tab.push_back(row(CMD_FILL,     -2048, -2048, 0,    0,   2047, 2047, 'h4a, 0, 1));
    dir_tab.push_back(row(CMD_FILL,     60,    60,    0,    0,   2047, 2047, 'h4b, 0, 1));
    dir_tab.push_back(row(CMD_UNUSED,   -1,    -1,    -1,   -1,  2047, 2047, 'hff, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    send_gaps = 1'b1;
    recv_gaps = 1'b1;

    foreach (dir_tab[i]) issue_cmd(dir_tab[i].item, dir_tab[i].by_model, dir_tab[i].want);
    for (int n = 0; n < 400; n++) issue_cmd(random_cmd(), 1'b1, nil);

    // receiver stuck: one finished result parks and the engine backs up
    wait_idle();
    send_gaps = 1'b0;
    long_hold_req = 1'b1;
    for (int n = 0; n < 30; n++) begin
      it = random_cmd();
      it.cmd = ($urandom_range(0, 1) != 0) ? CMD_PLOT : CMD_READ;
      issue_cmd(it, 1'b1, nil);
    end
    wait_idle();

    send_gaps = 1'b1;
    for (int n = 0; n < 450; n++) issue_cmd(random_cmd(), 1'b1, nil);

    // back to back on both sides
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    for (int n = 0; n < 170; n++) issue_cmd(random_cmd(), 1'b1, nil);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("commands: %0d plots, %0d lines, %0d spans, %0d rects, %0d reads, %0d unused",
             cmd_cnt[CMD_PLOT], cmd_cnt[CMD_LINE], cmd_cnt[CMD_HSPAN] + cmd_cnt[CMD_VSPAN],
             cmd_cnt[CMD_OUTLINE] + cmd_cnt[CMD_FILL], cmd_cnt[CMD_READ], cmd_cnt[CMD_UNUSED]);
    $display("results checked: %0d, with clipping: %0d, mismatches: %0d",
             checked_cnt, clip_cnt, err_cnt);
    if (err_cnt == 0 && cmd_status_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
